/* hdl/integer_to_ascii_radix_macros.svh */
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ITOA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ITOA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/itoa_pkg.sv */
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_DIGITS_DEF  = 64;

  localparam int IN_VALUE_W = 64;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int LEN_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] DEC_BASE    = 6'd10;
  localparam logic [DIGIT_W-1:0] ALPHA_COUNT = 6'd26;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

  typedef struct packed {
    logic                  cmd;
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } num_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              negative;
    logic [LEN_W-1:0]  total_length;
    logic              last;
  } chr_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LD
  } itoa_state_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_BASE) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A + dx - {1'b0, DEC_BASE};
    end
  endfunction

endpackage

/* hdl/itoa_ram.sv */
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/itoa_div.sv */
module itoa_div #(
  parameter int WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WIDTH-1:0]             dividend,
  input  logic [itoa_pkg::RADIX_W-1:0] divisor,
  output logic                         done,
  output logic [WIDTH-1:0]             quotient,
  output logic [itoa_pkg::DIGIT_W-1:0] remainder
);

  import itoa_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [RADIX_W-1:0] dvs;
  logic [DIGIT_W:0]   shifted;
  logic [DIGIT_W:0]   diff;
  logic               ge;

  // Restoring division, one quotient bit per cycle, MSB first. The quotient
  // register starts out holding the dividend and fills from the bottom.
  always_comb begin
    shifted = {remainder, quotient[WIDTH-1]};
    ge      = shifted >= (DIGIT_W+1)'(dvs);
    diff    = shifted - (DIGIT_W+1)'(dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(WIDTH - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[WIDTH-2:0], ge};
      remainder <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end
  end

endmodule

/* hdl/integer_to_ascii_radix.sv */
// Integer to ASCII conversion in radix 2 to 36.
// The num channel takes one item: cmd (signed mode), value and radix. Radix
// values below 2 or above 36 are clamped. Only the low VALUE_WIDTH bits of
// value are used. The chr channel returns one item per digit, most significant
// first, as '0'-'9' then 'A'-'Z', each carrying the negative flag, the total
// string length (sign counted) and a last flag on the least significant digit.
// Zero gives a single '0'. At most MAX_DIGITS low-order digits are kept.
// Each digit comes from one pass of a shared bit-serial divider; the digits
// are then read back from a small RAM through a read state and a load state.
// num_ready stays low while an item is in progress. A zero skips the divider.
// The last digit sits in an output register, so the next item is accepted
// while it waits. When chr_ready is low the output register holds its item
// and the read-back pauses. Reset returns the sequencer to idle and empties
// the output register; the digit RAM needs no clearing.
`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itoa_pkg::MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 num_valid,
  output logic                 num_ready,
  input  itoa_pkg::num_item_t  num,
  output logic                 chr_valid,
  input  logic                 chr_ready,
  output itoa_pkg::chr_item_t  chr
);

  import itoa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  itoa_state_t        state, state_next;
  logic [CNT_W-1:0]   n, n_next;
  logic [ADDR_W-1:0]  addr, addr_next;
  logic               sign, sign_next;
  logic [RADIX_W-1:0] radix, radix_next;

  logic [VALUE_WIDTH-1:0] val_w;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   neg_in;
  logic [RADIX_W-1:0]     radix_clamped;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]     div_rem;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;

  logic chr_load;

  always_comb begin
    val_w  = num.value[VALUE_WIDTH-1:0];
    neg_in = num.cmd & val_w[VALUE_WIDTH-1];
    // The most negative value negates to itself, which read unsigned is 2^(W-1).
    mag_in = neg_in ? (~val_w + 1'b1) : val_w;
    priority if (num.radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (num.radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = num.radix;
    end
  end

  itoa_div #(
    .WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_next),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      addr  <= '0;
      sign  <= 1'b0;
      radix <= RADIX_MIN;
    end else begin
      state <= state_next;
      n     <= n_next;
      addr  <= addr_next;
      sign  <= sign_next;
      radix <= radix_next;
    end
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    addr_next    = addr;
    sign_next    = sign;
    radix_next   = radix;
    num_ready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quo;
    ram_we       = 1'b0;
    ram_waddr    = n[ADDR_W-1:0];
    ram_wdata    = div_rem;
    ram_re       = 1'b0;
    chr_load     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        num_ready = 1'b1;
        if (num_valid) begin
          sign_next  = neg_in;
          radix_next = radix_clamped;
          if (mag_in == '0) begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = '0;
            n_next     = CNT_W'(1);
            addr_next  = '0;
            state_next = ST_RD;
          end else begin
            n_next       = '0;
            div_start    = 1'b1;
            div_dividend = mag_in;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_we = 1'b1;
          n_next = n + CNT_W'(1);
          if (div_quo == '0 || n_next == CNT_W'(MAX_DIGITS)) begin
            addr_next  = n[ADDR_W-1:0];
            state_next = ST_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_RD: begin
        ram_re     = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (!chr_valid || chr_ready) begin
          chr_load = 1'b1;
          if (addr == '0) begin
            state_next = ST_IDLE;
          end else begin
            addr_next  = addr - 1'b1;
            state_next = ST_RD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (chr_load) begin
      chr_valid <= 1'b1;
    end else if (chr_ready) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chr_load) begin
      chr.digit_char   <= digit_ascii(ram_rdata);
      chr.negative     <= sign;
      chr.total_length <= LEN_W'(n) + LEN_W'(sign);
      chr.last         <= (addr == '0);
    end
  end

  `ITOA_ASSERT_IMP(a_div_done_in_div, div_done, state == ST_DIV,
                   "divider finished outside the divide state")
  `ITOA_ASSERT_IMP(a_digit_below_radix, ram_we, ram_wdata < radix_next,
                   "stored digit not below the radix")
  `ITOA_ASSERT_IMP(a_char_legal, chr_valid,
                   (chr.digit_char >= CHAR_ZERO &&
                    chr.digit_char < CHAR_ZERO + {1'b0, DEC_BASE}) ||
                   (chr.digit_char >= CHAR_A &&
                    chr.digit_char < CHAR_A + {1'b0, ALPHA_COUNT}),
                   "digit character out of range")
  `ITOA_ASSERT_NXT(a_last_ends_run, chr_load && addr == '0,
                   chr_valid && chr.last && state == ST_IDLE,
                   "final digit not flagged or run not closed")

endmodule

/* bench/integer_to_ascii_radix_tb.sv */
module integer_to_ascii_radix_tb;
  import itoa_pkg::*;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ODD_BITS      = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] EVEN_BITS     = 64'h5555_5555_5555_5555;

  localparam int DECIMAL_DIGITS = 10;
  localparam int DIGIT_SLOTS    = 64;
  localparam int MAX_WAIT       = 11;
  localparam int STALL_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 150;
  localparam int REPORT_LIMIT   = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      num_valid = 1'b0;
  logic      num_ready;
  num_item_t num = '0;
  logic      chr_valid;
  logic      chr_ready = 1'b0;
  chr_item_t chr;

  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;

  chr_item_t expected_chars[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        rx_hold = 0;

  integer_to_ascii_radix dut (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr)
  );

  always #5 clk = ~clk;

  function automatic void flag_error(input string msg);
    if (mismatches < REPORT_LIMIT) begin
      $display("%s", msg);
    end
    mismatches++;
  endfunction

  // Works out the digit string of one number item and queues one character per digit.
  function automatic void predict_chars(input num_item_t it);
    logic [63:0]        mag;
    logic [RADIX_W-1:0] base;
    logic               neg;
    logic [DIGIT_W-1:0] digs[DIGIT_SLOTS];
    logic [DIGIT_W-1:0] d;
    int                 n;
    chr_item_t          c;
    base = it.radix;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    neg = (it.cmd == MODE_SIGNED) && it.value[63];
    mag = neg ? -it.value : it.value;
    n = 0;
    if (mag == 64'd0) begin
      digs[0] = '0;
      n = 1;
    end
    while (mag != 64'd0 && n < DIGIT_SLOTS) begin
      digs[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      d = digs[i];
      if (d < DECIMAL_DIGITS) begin
        c.digit_char = CHAR_ZERO + CHAR_W'(d);
      end else begin
        c.digit_char = CHAR_A + CHAR_W'(d - DECIMAL_DIGITS);
      end
      c.negative     = neg;
      c.total_length = LEN_W'(n + neg);
      c.last         = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // The sender keeps valid high from one item to the next when it draws no gap.
  task automatic send_number(input logic cmd, input logic [63:0] value,
                             input logic [RADIX_W-1:0] radix);
    num_item_t it;
    int        gap;
    it.cmd   = cmd;
    it.value = value;
    it.radix = radix;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      num_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num       <= it;
    num_valid <= 1'b1;
    do @(posedge clk); while (!num_ready);
    predict_chars(it);
  endtask

  task automatic wait_idle();
    num_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = {$urandom, $urandom};
      3:       v = 64'($urandom_range(0, 999));
      4:       v = -64'($urandom_range(1, 999));
      5:       v = 64'd1 << $urandom_range(0, 63);
      6:       v = (64'd1 << $urandom_range(0, 63)) - 64'd1;
      default: v = 64'($signed($urandom));
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 3) == 0) begin
      return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  task automatic test_zero();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_number(MODE_UNSIGNED, 64'd0, 6'd10);
    send_number(MODE_SIGNED, 64'd0, 6'd2);
    send_number(MODE_UNSIGNED, 64'd0, 6'd36);
    wait_idle();
  endtask

  task automatic test_unsigned_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_number(MODE_UNSIGNED, ALL_ONES, 6'd2);
    send_number(MODE_UNSIGNED, ALL_ONES, 6'd36);
    send_number(MODE_UNSIGNED, ALL_ONES, 6'd10);
    send_number(MODE_UNSIGNED, MOST_NEGATIVE, 6'd16);
    send_number(MODE_UNSIGNED, 64'd1, 6'd2);
    send_number(MODE_UNSIGNED, 64'd35, 6'd36);
    send_number(MODE_UNSIGNED, 64'd9, 6'd10);
    send_number(MODE_UNSIGNED, 64'd10, 6'd11);
    wait_idle();
  endtask

  // The most negative value has no positive counterpart and must come out as 2^63.
  task automatic test_signed_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    send_number(MODE_SIGNED, ALL_ONES, 6'd10);
    send_number(MODE_SIGNED, MOST_NEGATIVE, 6'd10);
    send_number(MODE_SIGNED, MOST_NEGATIVE, 6'd2);
    send_number(MODE_SIGNED, MOST_POSITIVE, 6'd16);
    send_number(MODE_SIGNED, -64'd36, 6'd36);
    send_number(MODE_SIGNED, ODD_BITS, 6'd8);
    wait_idle();
  endtask

  task automatic test_radix_clamp();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    send_number(MODE_UNSIGNED, 64'd255, 6'd0);
    send_number(MODE_UNSIGNED, 64'd255, 6'd1);
    send_number(MODE_UNSIGNED, 64'd255, 6'd37);
    send_number(MODE_SIGNED, 64'd255, 6'd63);
    send_number(MODE_UNSIGNED, EVEN_BITS, 6'd62);
    wait_idle();
  endtask

  task automatic test_random_back_to_back();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (40) begin
      send_number(logic'($urandom_range(0, 1)), pick_value(), pick_radix());
    end
    wait_idle();
  endtask

  // Idling on each side is redrawn every 16 items, so stretches without gaps occur too.
  task automatic test_random_with_idling();
    for (int i = 0; i < 320; i++) begin
      if (i % 16 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      send_number(logic'($urandom_range(0, 1)), pick_value(), pick_radix());
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    chr_item_t want;
    if (rst) begin
      chr_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (chr_valid && chr_ready) begin
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("unexpected character: digit_char=%h negative=%b total_length=%0d last=%b",
                               chr.digit_char, chr.negative, chr.total_length, chr.last));
        end else begin
          want = expected_chars.pop_front();
          if (chr.digit_char !== want.digit_char || chr.negative !== want.negative ||
              chr.total_length !== want.total_length || chr.last !== want.last) begin
            flag_error($sformatf({"character mismatch: expected digit_char=%h negative=%b ",
                                  "total_length=%0d last=%b, got digit_char=%h negative=%b ",
                                  "total_length=%0d last=%b"},
                                 want.digit_char, want.negative, want.total_length, want.last,
                                 chr.digit_char, chr.negative, chr.total_length, chr.last));
          end
        end
        rx_hold = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (rx_hold > 0) begin
        chr_ready <= 1'b0;
        rx_hold--;
      end else begin
        chr_ready <= 1'b1;
      end
    end
  end

  // Long division of a 64-bit value in radix two keeps both channels quiet until
  // its first digit appears, so the limit sits well above that wait.
  always @(posedge clk) begin
    if (rst || (num_valid && num_ready) || (chr_valid && chr_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_zero();
    test_unsigned_extremes();
    test_signed_extremes();
    test_radix_clamp();
    test_random_back_to_back();
    test_random_with_idling();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/itoa_pkg.sv
hdl/itoa_ram.sv
hdl/itoa_div.sv
hdl/integer_to_ascii_radix.sv
bench/integer_to_ascii_radix_tb.sv
